// ----- rtl/ffpc_pkg.sv -----
`timescale 1ns / 1ps

package ffpc_pkg;

    // Item kinds
    typedef enum logic [0:0] {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } t_func;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_LEAD_OFFSET = 2'd1;

    // Field and register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int HALF_W     = 13;
    localparam int LEAD_W     = 8;
    localparam int POS_W      = 13;
    localparam int CHAN_W     = 2;
    localparam int PIX_W      = 8;
    // lead + position + half width fits here without overflow
    localparam int SUM_W      = 15;
    localparam int PROD_W     = 16;

    // Reset values
    localparam logic [HALF_W-1:0] RESET_HALF = 13'd2048;
    localparam logic [LEAD_W-1:0] RESET_LEAD = 8'd4;

    // Gain adjust and output limits
    localparam logic [PIX_W-1:0]  GAIN_BIAS  = 8'd64;
    localparam logic [PIX_W-1:0]  GAIN_LIMIT = 8'd192;
    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
    localparam logic [PROD_W-1:0] PROD_LIMIT = 16'(255 << 6);
    localparam int                GAIN_FRAC  = 6;

    // Item held in the input register
    typedef struct packed {
        t_func              func;
        logic [CHAN_W-1:0]  chan;
        logic [SUM_W-1:0]   idx;
        logic [PIX_W-1:0]   gain;
        logic [PIX_W-1:0]   dark;
        logic [PIX_W-1:0]   pix;
    } t_s1;

endpackage

// ----- rtl/flat_field_pixel_correction_core.sv -----
`timescale 1ns / 1ps

// Flat-field shading correction for a contact image sensor. Each input item
// either loads one gain/dark entry of the per-column table of one channel, or
// corrects one pixel with the entry of its column (lead offset + position, plus
// half width on the obverse side). Every item passes through three stages: an
// input register that also forms the table index, a single-port table memory
// with registered read (at most one access per item, write for loads, read
// for pixels), and a result register holding the 8x8 multiply and saturation.
// A new item is accepted every cycle unless o_stall is high; a pixel's read
// data and then its result are registered, loads produce no result. The table
// holds no reset value, so a pixel must only use an entry that has been
// loaded. Configuration registers should be written only while idle.
module flat_field_pixel_correction_core #(
    parameter int TABLE_DEPTH = 8192,
    parameter int CHANNELS    = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [ffpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffpc_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // Input item channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [ffpc_pkg::CHAN_W-1:0]     i_channel,
    input  logic                            i_side,
    input  logic [ffpc_pkg::POS_W-1:0]      i_position,
    input  logic [ffpc_pkg::PIX_W-1:0]      i_gain_raw,
    input  logic [ffpc_pkg::PIX_W-1:0]      i_dark_offset,
    input  logic [ffpc_pkg::PIX_W-1:0]      i_pixel_in,

    // Result item channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ffpc_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                            o_index_error
);

    localparam int ENTRIES = CHANNELS * TABLE_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int WORD_W  = 2 * ffpc_pkg::PIX_W;

    localparam logic [ffpc_pkg::CHAN_W-1:0] CHAN_LIM  = ffpc_pkg::CHAN_W'(CHANNELS);
    localparam logic [ffpc_pkg::SUM_W-1:0]  DEPTH_LIM = ffpc_pkg::SUM_W'(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0]           DEPTH_A   = ADDR_W'(TABLE_DEPTH);

    // Configuration registers
    logic [ffpc_pkg::HALF_W-1:0] r_half;
    logic [ffpc_pkg::LEAD_W-1:0] r_lead;

    // Stage 1: input register
    logic           r1_valid;
    ffpc_pkg::t_s1  r1;
    ffpc_pkg::t_s1  n1;

    // Stage 2: table read data
    logic                          r2_valid;
    logic                          r2_err;
    logic [ffpc_pkg::PIX_W-1:0]    r2_pix;
    logic [WORD_W-1:0]             r_rd;

    // Stage 3: result register
    logic                          r3_valid;
    logic                          r3_err;
    logic [ffpc_pkg::PIX_W-1:0]    r3_pix;

    // Stage advance enables
    logic en1;
    logic en2;
    logic en3;

    logic [ffpc_pkg::SUM_W-1:0]  sum_idx;
    logic                        in_range;
    logic [ADDR_W-1:0]           addr;
    logic [ffpc_pkg::PIX_W-1:0]  rd_gain;
    logic [ffpc_pkg::PIX_W-1:0]  rd_dark;
    logic [ffpc_pkg::PIX_W-1:0]  diff;
    logic [ffpc_pkg::PROD_W-1:0] prod;
    logic [ffpc_pkg::PIX_W-1:0]  n3_pix;

    logic [WORD_W-1:0] r_mem [ENTRIES];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= ffpc_pkg::RESET_HALF;
            r_lead <= ffpc_pkg::RESET_LEAD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ffpc_pkg::CFG_HALF_WIDTH:  r_half <= i_cfg_data[ffpc_pkg::HALF_W-1:0];
                ffpc_pkg::CFG_LEAD_OFFSET: r_lead <= i_cfg_data[ffpc_pkg::LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage moves when the one after it is empty or moving
    assign en3     = !r3_valid || !i_stall;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_stall = !en1;

    // Column index and stored gain, formed on the way into stage 1
    always_comb begin
        sum_idx = ffpc_pkg::SUM_W'(r_lead) + ffpc_pkg::SUM_W'(i_position)
                + (i_side ? ffpc_pkg::SUM_W'(r_half) : '0);
        n1.func = ffpc_pkg::t_func'(i_func);
        n1.chan = i_channel;
        n1.idx  = (ffpc_pkg::t_func'(i_func) == ffpc_pkg::FUNC_PIXEL)
                ? sum_idx : ffpc_pkg::SUM_W'(i_position);
        n1.gain = (i_gain_raw < ffpc_pkg::GAIN_LIMIT)
                ? i_gain_raw + ffpc_pkg::GAIN_BIAS : ffpc_pkg::PIX_MAX;
        n1.dark = i_dark_offset;
        n1.pix  = i_pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r1 <= n1;
        end
    end

    // Range check and flat table address
    assign in_range = (r1.chan < CHAN_LIM) && (r1.idx < DEPTH_LIM);
    assign addr     = ADDR_W'(r1.chan) * DEPTH_A + ADDR_W'(r1.idx[IDX_W-1:0]);

    // Table memory: at most one write or one read per item, none when out of range
    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid && in_range) begin
            if (r1.func == ffpc_pkg::FUNC_LOAD) begin
                r_mem[addr] <= {r1.gain, r1.dark};
            end else begin
                r_rd <= r_mem[addr];
            end
        end
    end

    // Stage 2 control; loads end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid && (r1.func == ffpc_pkg::FUNC_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_err <= !in_range;
            r2_pix <= r1.pix;
        end
    end

    // Dark subtract, gain multiply and saturation
    assign rd_gain = r_rd[WORD_W-1:ffpc_pkg::PIX_W];
    assign rd_dark = r_rd[ffpc_pkg::PIX_W-1:0];
    assign diff    = (r2_pix > rd_dark) ? r2_pix - rd_dark : '0;
    assign prod    = ffpc_pkg::PROD_W'(rd_gain) * ffpc_pkg::PROD_W'(diff);

    always_comb begin
        if (r2_err) begin
            n3_pix = '0;
        end else if (prod > ffpc_pkg::PROD_LIMIT) begin
            n3_pix = ffpc_pkg::PIX_MAX;
        end else begin
            n3_pix = prod[ffpc_pkg::GAIN_FRAC +: ffpc_pkg::PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid) begin
            r3_err <= r2_err;
            r3_pix <= n3_pix;
        end
    end

    assign o_valid       = r3_valid;
    assign o_pixel_out   = r3_pix;
    assign o_index_error = r3_err;

`ifndef NO_ASSERTIONS
    // Input only stalls when the result register is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r3_valid && i_stall))
        else $error("input stalled without a held result");

    // A load never reaches the result side
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en2 && r1_valid && r1.func == ffpc_pkg::FUNC_LOAD) |=> !r2_valid)
        else $error("load item produced a result");

    // A flagged index always carries a zero pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_err) |-> (r3_pix == '0))
        else $error("index error with nonzero pixel");

    // A pixel waiting in stage 2 moves into the result register when it drains
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && en3) |=> r3_valid)
        else $error("pixel lost between stages");
`endif

endmodule

// ----- tb/sv/flat_field_pixel_correction_core_test.sv -----
`timescale 1ns / 1ps

module flat_field_pixel_correction_core_test;

    localparam int DEPTH          = 8192;
    localparam int NCHAN          = 3;
    localparam int PIPE_DRAIN     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 23;

    // Register indexes that map to nothing
    localparam logic [ffpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [ffpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        ffpc_pkg::t_func func;
        int              chan;
        bit              side;
        int              pos;
        int              graw;
        int              dark;
        int              pix;
    } t_item;

    typedef struct packed {
        logic [ffpc_pkg::PIX_W-1:0] pixel;
        logic                       err;
    } t_result;

    // DUT ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ffpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ffpc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic                            i_func = 1'b0;
    logic [ffpc_pkg::CHAN_W-1:0]     i_channel = '0;
    logic                            i_side = 1'b0;
    logic [ffpc_pkg::POS_W-1:0]      i_position = '0;
    logic [ffpc_pkg::PIX_W-1:0]      i_gain_raw = '0;
    logic [ffpc_pkg::PIX_W-1:0]      i_dark_offset = '0;
    logic [ffpc_pkg::PIX_W-1:0]      i_pixel_in = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [ffpc_pkg::PIX_W-1:0]      o_pixel_out;
    logic                            o_index_error;

    // Shadow of the block: registers, correction tables, loaded flags
    logic [ffpc_pkg::HALF_W-1:0] cfg_half = ffpc_pkg::RESET_HALF;
    logic [ffpc_pkg::LEAD_W-1:0] cfg_lead = ffpc_pkg::RESET_LEAD;
    logic [ffpc_pkg::PIX_W-1:0]  shade_gain [DEPTH*NCHAN];
    logic [ffpc_pkg::PIX_W-1:0]  shade_dark [DEPTH*NCHAN];
    bit                          entry_loaded [DEPTH*NCHAN];
    int                          loaded_addrs [$];
    t_result                     expected_pixels [$];

    int  errors = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;

    flat_field_pixel_correction_core #(
        .TABLE_DEPTH(DEPTH),
        .CHANNELS   (NCHAN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_channel    (i_channel),
        .i_side       (i_side),
        .i_position   (i_position),
        .i_gain_raw   (i_gain_raw),
        .i_dark_offset(i_dark_offset),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out),
        .o_index_error(o_index_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Predict one accepted item straight from the input ports
    function automatic void shade_item();
        int                          idx;
        int                          addr;
        int                          chan;
        logic [ffpc_pkg::PIX_W-1:0]  gain;
        logic [ffpc_pkg::PIX_W-1:0]  diff;
        logic [ffpc_pkg::PROD_W-1:0] prod;
        t_result                     res;
        chan = int'(i_channel);
        if (ffpc_pkg::t_func'(i_func) == ffpc_pkg::FUNC_LOAD) begin
            // loads to a missing channel are dropped
            if (chan < NCHAN && int'(i_position) < DEPTH) begin
                addr = chan * DEPTH + int'(i_position);
                shade_gain[addr] = (i_gain_raw < ffpc_pkg::GAIN_LIMIT)
                                 ? i_gain_raw + ffpc_pkg::GAIN_BIAS : ffpc_pkg::PIX_MAX;
                shade_dark[addr] = i_dark_offset;
                if (!entry_loaded[addr])
                    loaded_addrs.push_back(addr);
                entry_loaded[addr] = 1'b1;
            end
        end else begin
            idx = int'(cfg_lead) + int'(i_position) + (i_side ? int'(cfg_half) : 0);
            if (chan >= NCHAN || idx >= DEPTH) begin
                res.pixel = '0;
                res.err   = 1'b1;
            end else begin
                addr = chan * DEPTH + idx;
                gain = shade_gain[addr];
                diff = (i_pixel_in > shade_dark[addr]) ? i_pixel_in - shade_dark[addr] : '0;
                prod = ffpc_pkg::PROD_W'(gain) * ffpc_pkg::PROD_W'(diff);
                if (prod > ffpc_pkg::PROD_LIMIT)
                    prod = ffpc_pkg::PROD_LIMIT;
                res.pixel = ffpc_pkg::PIX_W'(prod >> ffpc_pkg::GAIN_FRAC);
                res.err   = 1'b0;
            end
            expected_pixels.push_back(res);
        end
    endfunction

    // Result check, prediction, register shadow and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected item: pixel_out %0d index_error %0d",
                           o_pixel_out, o_index_error);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_pixel_out !== want.pixel) begin
                        $error("pixel_out: expected %0d, actual %0d", want.pixel, o_pixel_out);
                        errors++;
                    end
                    if (o_index_error !== want.err) begin
                        $error("index_error: expected %0d, actual %0d",
                               want.err, o_index_error);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall)
                shade_item();
            if (i_cfg_we) begin
                if (i_cfg_idx == ffpc_pkg::CFG_HALF_WIDTH)
                    cfg_half = i_cfg_data[ffpc_pkg::HALF_W-1:0];
                else if (i_cfg_idx == ffpc_pkg::CFG_LEAD_OFFSET)
                    cfg_lead = i_cfg_data[ffpc_pkg::LEAD_W-1:0];
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("flat_field_pixel_correction_core_test: done, errors");
                $finish;
            end
        end
    end

    function automatic t_item make_item(ffpc_pkg::t_func f, int ch, bit sd, int pos,
                                        int graw, int dark, int pix);
        t_item it;
        it.func = f;
        it.chan = ch;
        it.side = sd;
        it.pos  = pos;
        it.graw = graw;
        it.dark = dark;
        it.pix  = pix;
        return it;
    endfunction

    // Drive one item from a falling edge, hold it until accepted
    task automatic send_item(input t_item it);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid       = 1'b0;
            i_position    = ffpc_pkg::POS_W'($urandom);
            i_pixel_in    = ffpc_pkg::PIX_W'($urandom);
            @(negedge i_clk);
        end
        i_func        = it.func;
        i_channel     = ffpc_pkg::CHAN_W'(it.chan);
        i_side        = it.side;
        i_position    = ffpc_pkg::POS_W'(it.pos);
        i_gain_raw    = ffpc_pkg::PIX_W'(it.graw);
        i_dark_offset = ffpc_pkg::PIX_W'(it.dark);
        i_pixel_in    = ffpc_pkg::PIX_W'(it.pix);
        i_valid       = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_load(input int ch, input int pos, input int graw, input int dark);
        send_item(make_item(ffpc_pkg::FUNC_LOAD, ch, bit'($urandom_range(1)), pos, graw,
                            dark, $urandom_range(255)));
    endtask

    // A pixel never reads an entry that was not loaded: load one first if needed
    task automatic send_pixel(input int ch, input bit sd, input int pos, input int pix);
        int idx;
        idx = int'(cfg_lead) + pos + (sd ? int'(cfg_half) : 0);
        if (ch < NCHAN && idx < DEPTH && !entry_loaded[ch * DEPTH + idx])
            send_load(ch, idx, $urandom_range(255), $urandom_range(255));
        send_item(make_item(ffpc_pkg::FUNC_PIXEL, ch, sd, pos, $urandom_range(255),
                            $urandom_range(255), pix));
    endtask

    // Stop sending and let the pipeline run empty
    task automatic settle();
        i_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ffpc_pkg::CFG_IDX_W-1:0] idx, input int data);
        settle();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = ffpc_pkg::CFG_DATA_W'(data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Reset register values, unit gain and a saturated product
    task automatic test_default_config();
        send_load(0, 4, 0, 0);
        send_pixel(0, 0, 0, 255);
        send_load(0, 5, 0, 3);
        send_pixel(0, 0, 1, 100);
        send_load(1, 2062, 191, 10);
        send_pixel(1, 1, 10, 200);
    endtask

    // Gain clamp at the top, dark level at or above the pixel
    task automatic test_gain_limits();
        send_load(2, 100, 192, 255);
        send_pixel(2, 0, 96, 0);
        send_pixel(2, 0, 96, 255);
        send_load(2, 101, 255, 0);
        send_pixel(2, 0, 97, 1);
        send_load(2, 102, 128, 254);
        send_pixel(2, 0, 98, 255);
    endtask

    // Missing channel and indexes at the table edge
    task automatic test_out_of_range();
        send_load(3, 8191, 255, 255);
        send_pixel(3, 0, 0, 255);
        send_pixel(0, 0, 8187, 255);
        send_pixel(0, 0, 8188, 255);
        send_pixel(2, 1, 8191, 255);
    endtask

    // Spare indexes do nothing, then both registers at their extremes
    task automatic test_config_registers();
        write_reg(CFG_SPARE_2, 13'h1FFF);
        write_reg(CFG_SPARE_3, 0);
        send_pixel(0, 0, 0, 128);
        write_reg(ffpc_pkg::CFG_HALF_WIDTH, 0);
        write_reg(ffpc_pkg::CFG_LEAD_OFFSET, 0);
        send_pixel(0, 1, 4, 77);
        write_reg(ffpc_pkg::CFG_HALF_WIDTH, 4096);
        // upper data bits fall off the 8-bit lead register
        write_reg(ffpc_pkg::CFG_LEAD_OFFSET, 13'h1FFF);
        send_pixel(0, 1, 3840, 200);
        send_pixel(0, 1, 3841, 200);
        send_pixel(1, 0, 0, 50);
    endtask

    // Mostly pixels on loaded columns, some fresh columns, misses and noise
    task automatic run_traffic(input int count);
        int    r;
        int    addr;
        int    ch;
        int    ix;
        int    base;
        bit    sd;
        t_item it;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(99);
            sd = bit'($urandom_range(1));
            base = int'(cfg_lead) + (sd ? int'(cfg_half) : 0);
            if (r < 45 && loaded_addrs.size() != 0) begin
                addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
                ch = addr / DEPTH;
                ix = addr % DEPTH;
                if (ix < base) begin
                    sd   = 1'b0;
                    base = int'(cfg_lead);
                end
                if (ix >= base)
                    send_pixel(ch, sd, ix - base, $urandom_range(255));
                else
                    send_pixel(ch, sd, $urandom_range(DEPTH - 1 - base), $urandom_range(255));
            end else if (r < 70) begin
                send_pixel($urandom_range(NCHAN - 1), sd, $urandom_range(DEPTH - 1 - base),
                           $urandom_range(255));
            end else if (r < 85) begin
                send_load($urandom_range(NCHAN - 1), $urandom_range(DEPTH - 1),
                          $urandom_range(255), $urandom_range(255));
            end else if (r < 92) begin
                if (base == 0)
                    send_pixel(3, sd, $urandom_range(DEPTH - 1), $urandom_range(255));
                else
                    send_pixel($urandom_range(3), sd, $urandom_range(DEPTH - 1, DEPTH - base),
                               $urandom_range(255));
            end else begin
                it = make_item(ffpc_pkg::t_func'($urandom_range(1)), $urandom_range(3),
                               bit'($urandom_range(1)), $urandom_range(DEPTH - 1),
                               $urandom_range(255), $urandom_range(255), $urandom_range(255));
                if (it.func == ffpc_pkg::FUNC_PIXEL)
                    send_pixel(it.chan, it.side, it.pos, it.pix);
                else
                    send_item(it);
            end
        end
    endtask

    // Several register settings, the extremes among them
    task automatic test_random_traffic();
        int half_set [7];
        int lead_set [7];
        half_set = '{0, 4096, 4096, 0, 2048, 0, 0};
        lead_set = '{0, 255, 0, 255, 4, 0, 0};
        half_set[5] = $urandom_range(4096);
        lead_set[5] = $urandom_range(255);
        half_set[6] = $urandom_range(4096);
        lead_set[6] = $urandom_range(255);
        for (int s = 0; s < 7; s++) begin
            write_reg(ffpc_pkg::CFG_HALF_WIDTH, half_set[s]);
            write_reg(ffpc_pkg::CFG_LEAD_OFFSET, lead_set[s]);
            run_traffic(165);
        end
    endtask

    // Full rate on both sides, no gaps and no backpressure
    task automatic test_back_to_back();
        write_reg(ffpc_pkg::CFG_HALF_WIDTH, $urandom_range(4096));
        write_reg(ffpc_pkg::CFG_LEAD_OFFSET, $urandom_range(255));
        no_idle = 1'b1;
        run_traffic(150);
        settle();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_config();
        test_gain_limits();
        test_out_of_range();
        test_config_registers();
        test_random_traffic();
        test_back_to_back();

        settle();
        if (errors == 0)
            $display("flat_field_pixel_correction_core_test: done, clean");
        else
            $display("flat_field_pixel_correction_core_test: done, errors");
        $finish;
    end

endmodule
